### rtl/esl_pkg.sv
// shared types and constants for the emergency stop latch
`timescale 1ns / 1ps
package esl_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LEVEL = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOW_PERIOD  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FAST_PERIOD  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_PERIOD  = 2'd3;

  localparam logic [1:0] MODE_NORMAL    = 2'd0;
  localparam logic [1:0] MODE_EMERGENCY = 2'd1;
  localparam logic [1:0] MODE_RESETTING = 2'd2;

  localparam logic [15:0] NORMAL_BLINK_RST = 16'd1000;
  localparam logic [15:0] FAST_BLINK_RST   = 16'd100;
  localparam logic [15:0] RESET_HOLD_RST   = 16'd2000;
  localparam logic [15:0] TRIPS_MAX        = 16'hffff;

  typedef struct packed {
    logic        stop_level;
    logic [31:0] time_ms;
  } esl_in_t;

  typedef struct packed {
    logic        led_level;
    logic        buzzer_level;
    logic [1:0]  mode_code;
    logic [15:0] trip_count;
  } esl_out_t;

  typedef struct packed {
    logic        active_level;
    logic [15:0] slow_period;
    logic [15:0] fast_period;
    logic [15:0] hold_period;
  } esl_cfg_t;

endpackage

### rtl/esl_cfg.sv
// configuration register file
`timescale 1ns / 1ps
module esl_cfg import esl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output esl_cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_level <= 1'b0;
      cfg.slow_period  <= NORMAL_BLINK_RST;
      cfg.fast_period  <= FAST_BLINK_RST;
      cfg.hold_period  <= RESET_HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE_LEVEL: cfg.active_level <= cfg_data[0];
        REG_SLOW_PERIOD:  cfg.slow_period  <= cfg_data;
        REG_FAST_PERIOD:  cfg.fast_period  <= cfg_data;
        REG_HOLD_PERIOD:  cfg.hold_period  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/esl_core.sv
// mode state machine, blink timer and trip counter
`timescale 1ns / 1ps
module esl_core import esl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     step,
  input  esl_in_t  item,
  input  esl_cfg_t cfg,
  output esl_out_t res
);

  logic [1:0]  mode, mode_next;
  logic [31:0] last_toggle, last_toggle_next;
  logic [31:0] release_start, release_start_next;
  logic        phase, phase_next;
  logic        led, led_next;
  logic        buzzer, buzzer_next;
  logic [15:0] trips, trips_next;

  logic        triggered;
  logic [15:0] interval;
  logic [31:0] blink_elapsed;
  logic [31:0] hold_elapsed;
  logic        blink_due;
  logic        hold_done;

  assign triggered     = (item.stop_level == cfg.active_level);
  assign interval      = (mode == MODE_EMERGENCY) ? cfg.fast_period : cfg.slow_period;
  // wrapping differences, compared unsigned
  assign blink_elapsed = item.time_ms - last_toggle;
  assign hold_elapsed  = item.time_ms - release_start;
  assign blink_due     = (blink_elapsed >= {16'd0, interval});
  assign hold_done     = (hold_elapsed >= {16'd0, cfg.hold_period});

  always_comb begin
    mode_next          = mode;
    last_toggle_next   = last_toggle;
    release_start_next = release_start;
    phase_next         = phase;
    led_next           = led;
    buzzer_next        = buzzer;
    trips_next         = trips;
    case (mode)
      MODE_EMERGENCY: begin
        if (blink_due) begin
          phase_next       = ~phase;
          led_next         = ~phase;
          last_toggle_next = item.time_ms;
        end
        buzzer_next = 1'b1;
        if (!triggered) begin
          mode_next          = MODE_RESETTING;
          release_start_next = item.time_ms;
          led_next           = 1'b1;
          buzzer_next        = 1'b0;
        end
      end
      MODE_RESETTING: begin
        led_next    = 1'b1;
        buzzer_next = 1'b0;
        if (triggered) begin
          mode_next = MODE_EMERGENCY;
        end else if (hold_done) begin
          mode_next  = MODE_NORMAL;
          phase_next = 1'b0;
          led_next   = 1'b0;
        end
      end
      default: begin
        mode_next = MODE_NORMAL;
        if (blink_due) begin
          phase_next       = ~phase;
          led_next         = ~phase;
          last_toggle_next = item.time_ms;
        end
        buzzer_next = 1'b0;
        if (triggered) begin
          if (trips != TRIPS_MAX) begin
            trips_next = trips + 16'd1;
          end
          mode_next = MODE_EMERGENCY;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_NORMAL;
      last_toggle   <= 32'd0;
      release_start <= 32'd0;
      phase         <= 1'b0;
      led           <= 1'b0;
      buzzer        <= 1'b0;
      trips         <= 16'd0;
    end else if (step) begin
      mode          <= mode_next;
      last_toggle   <= last_toggle_next;
      release_start <= release_start_next;
      phase         <= phase_next;
      led           <= led_next;
      buzzer        <= buzzer_next;
      trips         <= trips_next;
    end
  end

  always_comb begin
    res.led_level    = led_next;
    res.buzzer_level = buzzer_next;
    res.mode_code    = mode_next;
    res.trip_count   = trips_next;
  end

endmodule

### rtl/emergency_stop_latch_unit.sv
// Emergency stop latch top level.
// One input beat is one poll: the sampled stop level and a wrapping
// millisecond timestamp. Every poll yields exactly one result beat with
// the LED and buzzer levels, the mode (0 normal, 1 emergency, 2 resetting)
// and the saturating trip count.
// Both channels use valid/stall; a beat moves when valid is high and
// stall is low. Config registers are written through cfg_we/cfg_index/
// cfg_data and should only change while no poll is in flight.
// A poll is captured in the input register when it is accepted, and its
// result is loaded into the result register, which drives out_item, once
// that register is free.
// Throughput: one poll per cycle while out_stall is low, set by the
// combinational path from the mode/timer state through one wrapping
// subtract and compare back into the state and result registers.
// A stalled result holds; the stall backs up through the input register,
// so in_stall rises only once both stages are full.
// Reset (rst, synchronous) empties both stages, puts the block in normal
// mode with the LED and buzzer off and the trip count at zero, and loads
// the config defaults.
`timescale 1ns / 1ps
module emergency_stop_latch_unit import esl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  esl_in_t                in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output esl_out_t               out_item,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  esl_cfg_t cfg;
  esl_out_t res;
  esl_in_t  in_reg;
  logic     in_reg_valid;
  logic     out_load;
  logic     in_load;
  logic     step;

  // result register is free when empty or being drained
  assign out_load = !out_valid || !out_stall;
  assign in_load  = !in_reg_valid || out_load;
  assign in_stall = !in_load;
  assign step     = in_reg_valid && out_load;

  esl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  esl_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_reg),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_load) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && in_valid) begin
      in_reg <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item <= res;
    end
  end

endmodule

### rtl/esl_checker.sv
// port-level checks for the emergency stop latch, bound to the top level
`timescale 1ns / 1ps
module esl_checker import esl_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     out_valid,
  input logic     out_stall,
  input esl_out_t out_item
);

  // only the three defined mode codes are produced
  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.mode_code == MODE_NORMAL ||
                   out_item.mode_code == MODE_EMERGENCY ||
                   out_item.mode_code == MODE_RESETTING))
    else $error("unused mode code on result beat");

  // buzzer only sounds in emergency
  a_buzzer_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.buzzer_level) |-> (out_item.mode_code == MODE_EMERGENCY))
    else $error("buzzer on outside emergency mode");

  // resetting shows a solid led
  a_resetting_led: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.mode_code == MODE_RESETTING) |-> out_item.led_level)
    else $error("led off while resetting");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result beat changed");

endmodule

bind emergency_stop_latch_unit esl_checker u_esl_checker (.*);

### tb/sv/tb_top.sv
// self-checking testbench for the emergency stop latch unit
`timescale 1ns / 1ps
module tb_top import esl_pkg::*; ();

  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD   = 400;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  esl_in_t                in_item = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  esl_out_t               out_item;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_ACTIVE_LEVEL;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  emergency_stop_latch_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor copy of the configuration
  logic        cf_active = 1'b0;
  logic [15:0] cf_normal = NORMAL_BLINK_RST;
  logic [15:0] cf_fast   = FAST_BLINK_RST;
  logic [15:0] cf_hold   = RESET_HOLD_RST;

  // predictor copy of the latch state
  logic [1:0]  ls_mode = MODE_NORMAL;
  logic [31:0] ls_last_toggle = '0;
  logic [31:0] ls_release_at = '0;
  logic        ls_phase = 1'b0;
  logic        ls_led = 1'b0;
  logic        ls_buzz = 1'b0;
  logic [15:0] ls_trips = '0;

  esl_in_t  polls_pending[$];
  esl_out_t results_due[$];

  int          mismatches = 0;
  int          results_seen = 0;
  bit          gap_on = 1'b0;
  bit          stall_on = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  int unsigned hold_left = 0;
  int unsigned quiet = 0;

  // random sequence state
  logic [31:0] cur_ms = '0;
  int unsigned run_left = 0;
  bit          run_trig = 1'b0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic blink_step(input logic [31:0] now, input logic [15:0] interval);
    logic [31:0] since;
    since = now - ls_last_toggle;
    if (since >= {16'h0000, interval}) begin
      ls_phase = ~ls_phase;
      ls_led = ls_phase;
      ls_last_toggle = now;
    end
  endtask

  task automatic latch_poll(input esl_in_t p);
    logic        trig;
    logic [31:0] since;
    esl_out_t    r;
    trig = (p.stop_level == cf_active);
    case (ls_mode)
      MODE_EMERGENCY: begin
        blink_step(p.time_ms, cf_fast);
        ls_buzz = 1'b1;
        if (!trig) begin
          ls_mode = MODE_RESETTING;
          ls_release_at = p.time_ms;
          ls_led = 1'b1;
          ls_buzz = 1'b0;
        end
      end
      MODE_RESETTING: begin
        ls_led = 1'b1;
        ls_buzz = 1'b0;
        since = p.time_ms - ls_release_at;
        if (trig) begin
          ls_mode = MODE_EMERGENCY;
        end else if (since >= {16'h0000, cf_hold}) begin
          ls_mode = MODE_NORMAL;
          ls_phase = 1'b0;
          ls_led = 1'b0;
        end
      end
      default: begin
        // the unused code falls back to normal
        ls_mode = MODE_NORMAL;
        blink_step(p.time_ms, cf_normal);
        ls_buzz = 1'b0;
        if (trig) begin
          if (ls_trips != TRIPS_MAX) ls_trips = ls_trips + 16'd1;
          ls_mode = MODE_EMERGENCY;
        end
      end
    endcase
    r.led_level = ls_led;
    r.buzzer_level = ls_buzz;
    r.mode_code = ls_mode;
    r.trip_count = ls_trips;
    results_due.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40)
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) latch_poll(in_item);
      if (!(in_valid && in_stall)) begin
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
          in_valid <= 1'b0;
        end else if (polls_pending.size() > 0) begin
          in_item <= polls_pending.pop_front();
          in_valid <= 1'b1;
          in_gap = gap_on ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and stall generator
  always @(posedge clk) begin
    esl_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected beat", 32'(out_item), 32'd0);
        end else begin
          want = results_due.pop_front();
          if (out_item.led_level != want.led_level)
            report_mismatch("led_level", 32'(out_item.led_level), 32'(want.led_level));
          if (out_item.buzzer_level != want.buzzer_level)
            report_mismatch("buzzer_level", 32'(out_item.buzzer_level),
                            32'(want.buzzer_level));
          if (out_item.mode_code != want.mode_code)
            report_mismatch("mode_code", 32'(out_item.mode_code), 32'(want.mode_code));
          if (out_item.trip_count != want.trip_count)
            report_mismatch("trip_count", 32'(out_item.trip_count), 32'(want.trip_count));
        end
        results_seen++;
        // long hold-off so the pipeline fills and backs up into the input
        if (results_seen == 100 || results_seen == 900) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap = out_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        out_gap = stall_on ? pick_gap() : 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_ACTIVE_LEVEL: cf_active = data[0];
      REG_SLOW_PERIOD:  cf_normal = data;
      REG_FAST_PERIOD:  cf_fast = data;
      default:          cf_hold = data;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] act, input logic [15:0] nb,
                            input logic [15:0] fb, input logic [15:0] hold);
    write_reg(REG_ACTIVE_LEVEL, act);
    write_reg(REG_SLOW_PERIOD, nb);
    write_reg(REG_FAST_PERIOD, fb);
    write_reg(REG_HOLD_PERIOD, hold);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_poll(input logic lvl, input logic [31:0] t);
    esl_in_t p;
    p.stop_level = lvl;
    p.time_ms = t;
    polls_pending.push_back(p);
  endtask

  task automatic queue_random(input int n);
    int unsigned r;
    int unsigned scale;
    logic        lvl;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        queue_poll(1'($urandom_range(0, 1)), $urandom());
      end else begin
        // runs of triggered and released polls; time mostly moves forward, with jumps near the wrap or to random values
        if (run_left == 0) begin
          run_trig = ~run_trig;
          run_left = $urandom_range(1, 8);
        end
        run_left = run_left - 1;
        lvl = run_trig ? cf_active : ~cf_active;
        r = $urandom_range(0, 2);
        scale = 32'((r == 0) ? cf_normal : (r == 1) ? cf_fast : cf_hold);
        r = $urandom_range(0, 99);
        if (r < 10) begin
          cur_ms = cur_ms;
        end else if (r < 88) begin
          cur_ms = cur_ms + $urandom_range(0, scale + scale / 2);
        end else if (r < 95) begin
          cur_ms = 32'hffff_ffff - $urandom_range(0, scale);
        end else begin
          cur_ms = $urandom();
        end
        queue_poll(lvl, cur_ms);
      end
    end
  endtask

  task automatic wait_idle();
    while (polls_pending.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input int n, input bit gaps, input bit stalls);
    gap_on = gaps;
    stall_on = stalls;
    queue_random(n);
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    gap_on = 1'b1;
    stall_on = 1'b1;

    // directed polls on the reset defaults: low level triggers
    queue_poll(1'b1, 32'd0);
    queue_poll(1'b1, 32'd999);
    queue_poll(1'b1, 32'd1000);
    queue_poll(1'b1, 32'hffff_ffff);
    queue_poll(1'b1, 32'd999);           // heartbeat across the wrap
    queue_poll(1'b0, 32'd1000);          // trip
    queue_poll(1'b0, 32'd1099);
    queue_poll(1'b0, 32'd1100);
    queue_poll(1'b1, 32'd1150);          // release
    queue_poll(1'b0, 32'd1200);          // retrigger while resetting
    queue_poll(1'b0, 32'd1300);
    queue_poll(1'b1, 32'd1400);
    queue_poll(1'b1, 32'd3399);          // one short of the hold
    queue_poll(1'b1, 32'd3400);          // hold reached
    queue_poll(1'b0, 32'd3401);
    queue_poll(1'b1, 32'hffff_ff00);
    queue_poll(1'b1, 32'h0000_06d0);     // hold reached across the wrap
    queue_poll(1'b0, 32'hffff_ffff);
    queue_poll(1'b1, 32'd0);
    queue_poll(1'b1, 32'd0);
    wait_idle();

    set_config(16'd1, 16'd1, 16'd1, 16'd1);
    run_phase(200, 1'b1, 1'b1);
    set_config(16'd0, 16'hffff, 16'hffff, 16'hffff);
    run_phase(200, 1'b1, 1'b1);
    set_config(16'hfffe, 16'd37, 16'd5, 16'd120);
    run_phase(200, 1'b0, 1'b0);
    set_config(16'($urandom()), 16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)),
               16'($urandom_range(1, 300)));
    run_phase(200, 1'b1, 1'b1);
    set_config(16'($urandom()), 16'($urandom_range(1, 65535)),
               16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
    run_phase(200, 1'b1, 1'b0);
    set_config(16'($urandom()), 16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)),
               16'($urandom_range(1, 40)));
    run_phase(200, 1'b0, 1'b1);

    // back to back trip cycles: trip, release, hold of one
    set_config(16'($urandom()), 16'd1, 16'd1, 16'd1);
    gap_on = 1'b0;
    stall_on = 1'b0;
    for (int i = 0; i < 60; i++) begin
      queue_poll(cf_active, cur_ms);
      queue_poll(~cf_active, cur_ms + 32'd1);
      queue_poll(~cf_active, cur_ms + 32'd2);
      cur_ms = cur_ms + 32'd3;
    end
    wait_idle();

    set_config(16'($urandom()), 16'($urandom_range(1, 200)), 16'($urandom_range(1, 200)),
               16'($urandom_range(1, 200)));
    run_phase(200, 1'b1, 1'b1);

    repeat (8) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
